// ===== design/gams_pkg.sv =====
package gams_pkg;

  // Command codes of an input beat
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_SUCC = 2'd1;
  localparam logic [1:0] CMD_PRED = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_NEIGHBOR = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ADDED    = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] vertex_a;
    logic signed [31:0] vertex_b;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] neighbor;
    logic               last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic       start;
    logic       look;
    logic       add_a;
    logic       add_b;
    logic       row_rd;
    logic       row_wr;
    logic       load_rem;
    logic       scan;
    logic       resp;
    logic [2:0] resp_status;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic look_done;
    logic is_add;
    logic query_ok;
    logic room_ok;
    logic row_zero;
    logic rem_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/graph_adjacency_matrix_store_unit.sv =====
// Directed-graph store: 32-bit signed vertex labels are mapped to dense ids
// in order of first appearance, and edges live in a MAX_VERTICES square bit
// matrix (kept as rows plus a transposed copy, so both successor and
// predecessor lists come from one row read). Add-edge returns one beat:
// edge added, or table full with nothing changed. A successor or predecessor
// query returns one beat per neighbor label in id order with last set on the
// final one, or a single no-neighbors / unknown-vertex beat. One item is
// worked at a time; its length is set by any output stall and by the single
// read port of the label memory, which is walked once per item for the label
// lookup and once more per query to fetch neighbor labels. A result may sit
// in the output register while the next item is accepted. The matrix reads
// as empty right after reset (per-row valid bits), so no clearing pass is
// needed.
module graph_adjacency_matrix_store_unit #(
  parameter int MAX_VERTICES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  // input channel
  input  logic           in_valid,
  output logic           in_stall,
  input  gams_pkg::in_t  in_data,
  // result channel
  output logic           out_valid,
  input  logic           out_stall,
  output gams_pkg::out_t out_data
);
  import gams_pkg::*;

  ctrl_cmd_t cmd;   // controller -> datapath
  dp_stat_t  stat;  // datapath -> controller

  // sequencer: lookup, id assignment, row update or neighbor walk
  gams_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // label memory, adjacency memories, vertex count, output register
  gams_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/gams_dp.sv =====
module gams_dp #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gams_pkg::in_t        in_data,
  input  gams_pkg::ctrl_cmd_t  cmd,
  output gams_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gams_pkg::out_t       out_data
);
  import gams_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

  // captured item
  logic [1:0]         op_r;
  logic signed [31:0] a_r;
  logic signed [31:0] b_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [IW-1:0] ia_r, ia_nxt;
  logic [IW-1:0] ib_r, ib_nxt;
  logic [IW-1:0] rd_idx_r;
  logic          fa_r, fa_nxt;
  logic          fb_r, fb_nxt;
  logic          rd_vld_r, rd_vld_nxt;

  logic signed [31:0] label_mem [MAX_VERTICES];
  logic signed [31:0] lbl_q_r;

  logic [MAX_VERTICES-1:0] fwd_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rev_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] fwd_q_r, rev_q_r;
  logic                    fwd_qv_r, rev_qv_r;
  logic [MAX_VERTICES-1:0] fwd_vld_r, rev_vld_r;
  logic [MAX_VERTICES-1:0] rem_r, rem_nxt;

  logic out_vld_r, out_vld_nxt;
  out_t out_r, out_nxt;

  logic                    a_eq_b;
  logic                    rd_addr_ok;
  logic [IW-1:0]           rd_addr;
  logic                    scan_hit;
  logic                    out_free;
  logic                    emit;
  logic                    hold;
  logic                    rd_go;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic signed [31:0]      wr_data;
  logic [IW-1:0]           rev_addr;
  logic [MAX_VERTICES-1:0] fwd_eff, rev_eff, sel_row;
  logic [MAX_VERTICES-1:0] emit_bit;
  logic [1:0]              need;
  logic [CW:0]             need_sum;

  assign a_eq_b     = (a_r == b_r);
  assign rd_addr_ok = (scan_r < count_r);
  assign rd_addr    = rd_addr_ok ? scan_r[IW-1:0] : '0;
  assign scan_hit   = rd_vld_r && rem_r[rd_idx_r];
  assign out_free   = !out_vld_r || !out_stall;
  assign emit       = cmd.scan && scan_hit && out_free;
  assign hold       = cmd.scan && scan_hit && !out_free;
  assign rd_go      = (cmd.look || cmd.scan) && !hold;

  assign wr_en   = (cmd.add_a && !fa_r) || (cmd.add_b && !fb_r && !a_eq_b);
  assign wr_addr = count_r[IW-1:0];
  assign wr_data = cmd.add_a ? a_r : b_r;

  assign rev_addr = (op_r == CMD_ADD) ? ib_r : ia_r;
  assign fwd_eff  = fwd_qv_r ? fwd_q_r : '0;
  assign rev_eff  = rev_qv_r ? rev_q_r : '0;
  assign sel_row  = (op_r == CMD_SUCC) ? fwd_eff : rev_eff;
  assign emit_bit = ROW_ONE << rd_idx_r;

  assign need     = {1'b0, !fa_r} + {1'b0, (!fb_r && !a_eq_b)};
  assign need_sum = (CW+1)'(count_r) + (CW+1)'(need);

  always_comb begin
    stat.look_done = !rd_vld_r && !rd_addr_ok;
    stat.is_add    = (op_r == CMD_ADD);
    stat.query_ok  = ((op_r == CMD_SUCC) || (op_r == CMD_PRED)) && fa_r;
    stat.room_ok   = (need_sum <= (CW+1)'(MAX_VERTICES));
    stat.row_zero  = (sel_row == '0);
    stat.rem_zero  = (rem_r == '0);
    stat.out_free  = out_free;
  end

  always_comb begin
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    ia_nxt     = ia_r;
    ib_nxt     = ib_r;
    fa_nxt     = fa_r;
    fb_nxt     = fb_r;
    rd_vld_nxt = rd_vld_r;
    rem_nxt    = rem_r;
    if (cmd.start) begin
      scan_nxt   = '0;
      rd_vld_nxt = 1'b0;
      fa_nxt     = 1'b0;
      fb_nxt     = 1'b0;
    end
    if (rd_go) begin
      rd_vld_nxt = rd_addr_ok;
      if (rd_addr_ok) begin
        scan_nxt = scan_r + 1'b1;
      end
    end
    if (cmd.look && rd_vld_r) begin
      if (lbl_q_r == a_r && !fa_r) begin
        fa_nxt = 1'b1;
        ia_nxt = rd_idx_r;
      end
      if (lbl_q_r == b_r && !fb_r) begin
        fb_nxt = 1'b1;
        ib_nxt = rd_idx_r;
      end
    end
    if (cmd.add_a && !fa_r) begin
      ia_nxt    = count_r[IW-1:0];
      count_nxt = count_r + 1'b1;
    end
    if (cmd.add_b && !fb_r) begin
      if (a_eq_b) begin
        ib_nxt = ia_r;
      end else begin
        ib_nxt    = count_r[IW-1:0];
        count_nxt = count_r + 1'b1;
      end
    end
    if (cmd.load_rem) begin
      rem_nxt    = sel_row;
      scan_nxt   = '0;
      rd_vld_nxt = 1'b0;
    end
    if (emit) begin
      rem_nxt = rem_r & ~emit_bit;
    end
  end

  always_comb begin
    out_nxt     = out_r;
    out_vld_nxt = out_stall ? out_vld_r : 1'b0;
    if (emit) begin
      out_nxt.status   = ST_NEIGHBOR;
      out_nxt.neighbor = lbl_q_r;
      out_nxt.last     = ((rem_r & ~emit_bit) == '0);
      out_vld_nxt      = 1'b1;
    end else if (cmd.resp && out_free) begin
      out_nxt.status   = cmd.resp_status;
      out_nxt.neighbor = '0;
      out_nxt.last     = 1'b1;
      out_vld_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fwd_vld_r <= '0;
      rev_vld_r <= '0;
    end else begin
      count_r   <= count_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cmd.row_wr) begin
        fwd_vld_r[ia_r] <= 1'b1;
        rev_vld_r[ib_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= in_data.cmd;
      a_r  <= in_data.vertex_a;
      b_r  <= in_data.vertex_b;
    end
    scan_r <= scan_nxt;
    ia_r   <= ia_nxt;
    ib_r   <= ib_nxt;
    fa_r   <= fa_nxt;
    fb_r   <= fb_nxt;
    rem_r  <= rem_nxt;
    out_r  <= out_nxt;
    if (rd_go) begin
      rd_idx_r <= rd_addr;
    end
  end

  // label store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      label_mem[wr_addr] <= wr_data;
    end
    if (rd_go) begin
      lbl_q_r <= label_mem[rd_addr];
    end
  end

  // adjacency rows and their transpose
  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      fwd_q_r  <= fwd_mem[ia_r];
      fwd_qv_r <= fwd_vld_r[ia_r];
      rev_q_r  <= rev_mem[rev_addr];
      rev_qv_r <= rev_vld_r[rev_addr];
    end
    if (cmd.row_wr) begin
      fwd_mem[ia_r] <= fwd_eff | (ROW_ONE << ib_r);
      rev_mem[ib_r] <= rev_eff | (ROW_ONE << ia_r);
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_label_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r < CW'(MAX_VERTICES)))
    else $error("label write with full table");

  a_emit_known: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (CW'(rd_idx_r) < count_r))
    else $error("neighbor emitted for unassigned id");

  a_edge_ids: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_wr |-> ((CW'(ia_r) < count_r) && (CW'(ib_r) < count_r)))
    else $error("edge written for unassigned id");
`endif

endmodule

// ===== design/gams_ctrl.sv =====
module gams_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gams_pkg::dp_stat_t  stat,
  output gams_pkg::ctrl_cmd_t cmd
);
  import gams_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_LOOK    = 10'b00_0000_0010,
    S_DECIDE  = 10'b00_0000_0100,
    S_ADD_A   = 10'b00_0000_1000,
    S_ADD_B   = 10'b00_0001_0000,
    S_ROW_RD  = 10'b00_0010_0000,
    S_ROW_WR  = 10'b00_0100_0000,
    S_ROW_CHK = 10'b00_1000_0000,
    S_SCAN    = 10'b01_0000_0000,
    S_RESP    = 10'b10_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] resp_r, resp_nxt;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    cmd.resp_status = resp_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (stat.look_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_add) begin
          if (stat.room_ok) begin
            state_nxt = S_ADD_A;
          end else begin
            resp_nxt  = ST_FULL;
            state_nxt = S_RESP;
          end
        end else if (stat.query_ok) begin
          state_nxt = S_ROW_RD;
        end else begin
          resp_nxt  = ST_UNKNOWN;
          state_nxt = S_RESP;
        end
      end
      S_ADD_A: begin
        cmd.add_a = 1'b1;
        state_nxt = S_ADD_B;
      end
      S_ADD_B: begin
        cmd.add_b = 1'b1;
        state_nxt = S_ROW_RD;
      end
      S_ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_nxt  = stat.is_add ? S_ROW_WR : S_ROW_CHK;
      end
      S_ROW_WR: begin
        cmd.row_wr = 1'b1;
        resp_nxt   = ST_ADDED;
        state_nxt  = S_RESP;
      end
      S_ROW_CHK: begin
        cmd.load_rem = 1'b1;
        if (stat.row_zero) begin
          resp_nxt  = ST_EMPTY;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.rem_zero) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        cmd.resp = 1'b1;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    resp_r <= resp_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== dv/adjacency_store_checker.sv =====
`timescale 1ns / 100ps

module adjacency_store_checker #(
  parameter int MAX_VERTICES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  gams_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  gams_pkg::out_t out_data,
  output int             mismatches,
  output int             beats_due,
  output int             beats_checked
);
  import gams_pkg::*;

  // label per dense id, id count, and matrix rows (row = source id)
  logic signed [31:0]      label_of_id [MAX_VERTICES];
  int                      id_count;
  logic [MAX_VERTICES-1:0] edge_row    [MAX_VERTICES];
  out_t                    result_beats_due [$];

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int id_of(logic signed [31:0] lbl);
    for (int i = 0; i < id_count; i++)
      if (label_of_id[i] == lbl) return i;
    return -1;
  endfunction

  function automatic int claim_id(logic signed [31:0] lbl);
    label_of_id[id_count] = lbl;
    id_count++;
    return id_count - 1;
  endfunction

  function automatic logic is_link(logic [1:0] cmd, int qid, int other);
    return (cmd == CMD_SUCC) ? edge_row[qid][other] : edge_row[other][qid];
  endfunction

  task automatic queue_beat(logic [2:0] st, logic signed [31:0] nb, logic lst);
    out_t b;
    b.status   = st;
    b.neighbor = nb;
    b.last     = lst;
    result_beats_due = {result_beats_due, b};
  endtask

  task automatic apply_command(in_t c);
    int ia;
    int ib;
    int need;
    int hits;
    int k;
    case (c.cmd)
      CMD_ADD: begin
        ia   = id_of(c.vertex_a);
        ib   = id_of(c.vertex_b);
        need = 0;
        if (ia < 0) need++;
        if (ib < 0 && c.vertex_b != c.vertex_a) need++;
        if (need > MAX_VERTICES - id_count) begin
          queue_beat(ST_FULL, '0, 1'b1);
        end else begin
          if (ia < 0) ia = claim_id(c.vertex_a);
          if (ib < 0) ib = (c.vertex_b == c.vertex_a) ? ia : claim_id(c.vertex_b);
          edge_row[ia][ib] = 1'b1;
          queue_beat(ST_ADDED, '0, 1'b1);
        end
      end
      CMD_SUCC, CMD_PRED: begin
        ia = id_of(c.vertex_a);
        if (ia < 0) begin
          queue_beat(ST_UNKNOWN, '0, 1'b1);
        end else begin
          hits = 0;
          for (int i = 0; i < id_count; i++)
            if (is_link(c.cmd, ia, i)) hits++;
          if (hits == 0) begin
            queue_beat(ST_EMPTY, '0, 1'b1);
          end else begin
            k = 0;
            for (int i = 0; i < id_count; i++) begin
              if (is_link(c.cmd, ia, i)) begin
                k++;
                queue_beat(ST_NEIGHBOR, label_of_id[i], k == hits);
              end
            end
          end
        end
      end
      default: queue_beat(ST_UNKNOWN, '0, 1'b1);
    endcase
  endtask

  task automatic check_beat(out_t got);
    out_t want;
    if (result_beats_due.size() == 0) begin
      note_mismatch($sformatf("result beat with nothing due: status=%0d neighbor=%0d last=%0d",
                              got.status, got.neighbor, got.last));
    end else begin
      want = result_beats_due.pop_front();
      beats_checked++;
      if (got.status !== want.status)
        note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.neighbor !== want.neighbor)
        note_mismatch($sformatf("neighbor %0d, want %0d", got.neighbor, want.neighbor));
      if (got.last !== want.last)
        note_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      id_count      = 0;
      mismatches    = 0;
      beats_checked = 0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        edge_row[i]    = '0;
        label_of_id[i] = '0;
      end
      result_beats_due.delete();
    end else begin
      // a command's results never leave in the beat it is taken
      if (in_valid && !in_stall) apply_command(in_data);
      if (out_valid && !out_stall) check_beat(out_data);
    end
    beats_due = result_beats_due.size();
  end

endmodule

// ===== dv/graph_adjacency_matrix_store_unit_test.sv =====
`timescale 1ns / 100ps

module graph_adjacency_matrix_store_unit_test;
  import gams_pkg::*;

  localparam int MAX_VERTICES = 32;
  // label pool: more labels than ids, so the table can be driven full
  localparam int POOL_SIZE    = 40;
  // worst case is a 32-beat list per command under heavy output stall
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 100;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;

  int mismatches;
  int beats_due;
  int beats_checked;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;
  int commands_sent = 0;

  logic signed [31:0] pool [POOL_SIZE];
  // stimulus-side record of which pool labels own an id; only pool labels
  // are added while the table still has room, so this stays exact
  bit pool_known [POOL_SIZE];
  int known_count = 0;

  graph_adjacency_matrix_store_unit #(
    .MAX_VERTICES(MAX_VERTICES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  adjacency_store_checker #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .beats_due    (beats_due),
    .beats_checked(beats_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result-side backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  function automatic in_t make_beat(logic [1:0] c, logic signed [31:0] a,
                                    logic signed [31:0] b);
    in_t t;
    t.cmd      = c;
    t.vertex_a = a;
    t.vertex_b = b;
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is
  // taken, so valid is only ever assigned once per step.
  task automatic send_beat(in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    commands_sent++;
    @(negedge clk);
  endtask

  // add edge between two pool labels, tracking which labels get ids
  task automatic add_pool(int ia, int ib);
    int need;
    need = 0;
    if (!pool_known[ia]) need++;
    if (!pool_known[ib] && ia != ib) need++;
    if (known_count + need <= MAX_VERTICES) begin
      pool_known[ia] = 1'b1;
      pool_known[ib] = 1'b1;
      known_count += need;
    end
    send_beat(make_beat(CMD_ADD, pool[ia], pool[ib]));
  endtask

  task automatic query_pool(logic [1:0] c, int ia);
    send_beat(make_beat(c, pool[ia], $urandom()));
  endtask

  function automatic int next_unknown(int from);
    for (int i = from; i < POOL_SIZE; i++)
      if (!pool_known[i]) return i;
    return -1;
  endfunction

  task automatic set_mix(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Mostly well-formed adds and queries over the first span pool labels;
  // the rest is noise: foreign labels, the spare command code, and (once the
  // table is full) adds of foreign labels.
  task automatic random_beat(int span, bit foreign_adds);
    int pick;
    int ia;
    pick = $urandom_range(99);
    ia   = $urandom_range(span - 1);
    if (pick < 40) begin
      add_pool(ia, ($urandom_range(7) == 0) ? ia : $urandom_range(span - 1));
    end else if (pick < 88) begin
      query_pool($urandom_range(1) ? CMD_SUCC : CMD_PRED, ia);
    end else begin
      case ($urandom_range(2))
        0: send_beat(make_beat($urandom_range(1) ? CMD_SUCC : CMD_PRED,
                               $urandom(), $urandom()));
        1: send_beat(make_beat(CMD_RSVD, $urandom_range(1) ? pool[ia] : $urandom(),
                               $urandom()));
        default: send_beat(make_beat(foreign_adds ? CMD_ADD : CMD_PRED,
                                     $urandom(), $urandom()));
      endcase
    end
  endtask

  initial begin
    int u;
    int w;

    // extremes first, then well-spread distinct labels
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7FFF_FFFF;
    pool[2] = 32'sh0000_0000;
    pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) pool[i] = i * 32'h9E37_79B9;
    for (int i = 0; i < POOL_SIZE; i++) pool_known[i] = 1'b0;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed, no idling ---
    set_mix(0, 0);
    query_pool(CMD_SUCC, 0);                            // empty store: unknown
    query_pool(CMD_PRED, 1);
    send_beat(make_beat(CMD_RSVD, pool[3], pool[1]));   // spare code
    add_pool(0, 1);                                     // min -> max
    add_pool(0, 1);                                     // repeated edge
    add_pool(2, 2);                                     // self loop, unseen label
    add_pool(3, 0);
    add_pool(0, 3);
    add_pool(0, 2);
    query_pool(CMD_SUCC, 0);                            // three neighbors
    query_pool(CMD_PRED, 0);
    query_pool(CMD_SUCC, 1);                            // known, no successors
    query_pool(CMD_PRED, 2);                            // includes itself
    query_pool(CMD_SUCC, 2);
    send_beat(make_beat(CMD_RSVD, pool[0], pool[2]));   // spare code, known label
    send_beat(make_beat(CMD_SUCC, $urandom(), $urandom()));
    query_pool(CMD_PRED, 3);
    add_pool(4, 5);                                     // two unseen at once
    query_pool(CMD_SUCC, 4);
    query_pool(CMD_PRED, 5);

    // --- random over a small label set, sender mostly idle ---
    set_mix(82, 0);
    repeat (110) random_beat(20, 1'b0);

    // hold off until every result of the phase is back
    in_valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);

    // --- fill the table to one free id, then probe the full cases ---
    set_mix(0, 82);
    while (known_count < MAX_VERTICES - 2) begin
      u = next_unknown(0);
      w = next_unknown(u + 1);
      add_pool(u, w);
    end
    if (known_count == MAX_VERTICES - 2) add_pool(next_unknown(0), next_unknown(0));
    u = next_unknown(0);
    w = next_unknown(u + 1);
    add_pool(u, w);            // two new labels, one free id: full
    add_pool(u, 0);            // takes the last id
    add_pool(w, w);            // self loop, unseen, no room
    add_pool(0, w);            // one new label, no room
    add_pool(0, 1);            // repeat still accepted when full
    query_pool(CMD_SUCC, 0);
    query_pool(CMD_PRED, 0);
    query_pool(CMD_SUCC, w);   // refused label stays unknown

    // --- random over the whole pool, table full ---
    set_mix(33, 33);
    repeat (100) random_beat(POOL_SIZE, 1'b1);
    set_mix(0, 82);
    repeat (80) random_beat(POOL_SIZE, 1'b1);
    set_mix(0, 0);
    repeat (60) random_beat(POOL_SIZE, 1'b1);

    in_valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d commands (directed, table fill to capacity, random adds/queries/noise)",
             commands_sent);
    $display("under four sender/receiver idle mixes; %0d result beats checked, %0d mismatches",
             beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
